FILE: hdl/reprojection_error_distorted_pinhole_top_defines.svh
// Assertion macros shared by the reprojection error block.
`ifndef REPROJECTION_ERROR_DISTORTED_PINHOLE_TOP_DEFINES_SVH
`define REPROJECTION_ERROR_DISTORTED_PINHOLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RPE_ASSERT(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");
`define RPE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define RPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define RPE_ASSERT(lbl, cond)
`define RPE_ASSERT_IMPL(lbl, ante, cons)
`define RPE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/rpe_pkg.sv
// Types, constants and helpers of the reprojection error block.
package rpe_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int SAT_W      = (WORD_WIDTH < 32) ? WORD_WIDTH : 32;
	localparam logic signed [63:0] SAT_MAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
	localparam logic signed [63:0] SAT_MIN = -(64'sd1 <<< (SAT_W - 1));

	localparam int POSE_WORDS = 12;
	localparam int NUM_REGS   = 8;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_SEL_W  = 3;
	localparam int SLOT_W     = 4;

	// camera coordinate, dividend and divisor widths
	localparam int C_W   = 37;
	localparam int N_W   = C_W + 16;
	localparam int D_W   = C_W - 1;
	localparam int QB    = 32;
	localparam int CMP_W = D_W + QB + 1;

	localparam logic signed [63:0] ONE_Q16 = 64'sd65536;

	typedef enum logic [CFG_SEL_W-1:0] {
		REG_FX, REG_FY, REG_CX, REG_CY, REG_K1, REG_K2, REG_P1, REG_P2
	} reg_idx_t;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_PROJECT = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_DEPTH = 2'd1,
		STATUS_SAT   = 2'd2
	} status_t;

	typedef struct packed {
		action_t            action;
		logic [SLOT_W-1:0]  pose_slot;
		logic signed [31:0] pose_word;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [31:0] measured_x;
		logic signed [31:0] measured_y;
	} obs_t;

	typedef struct packed {
		logic [63:0] squared_error;
		status_t     status;
	} res_t;

	// travels through the divider beside the quotient
	typedef struct packed {
		logic               bad;
		logic               neg_x;
		logic               neg_y;
		logic signed [31:0] meas_x;
		logic signed [31:0] meas_y;
	} div_side_t;

	// bit 32 flags saturation, bits 31:0 hold the clamped word
	function automatic logic [32:0] sat_w(input logic signed [63:0] v);
		if (v > SAT_MAX) return {1'b1, SAT_MAX[31:0]};
		else if (v < SAT_MIN) return {1'b1, SAT_MIN[31:0]};
		else return {1'b0, v[31:0]};
	endfunction

endpackage

FILE: hdl/rpe_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module rpe_divider import rpe_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [N_W-1:0]  num_x,
	input  logic [N_W-1:0]  num_y,
	input  logic [D_W-1:0]  den,
	input  div_side_t       side_in,
	output logic            out_valid,
	output logic [QB-1:0]   q_x,
	output logic [QB-1:0]   q_y,
	output logic            ovf_x,
	output logic            ovf_y,
	output div_side_t       side_out
);

	typedef struct packed {
		logic [N_W-1:0] rem_x;
		logic [N_W-1:0] rem_y;
		logic [QB-1:0]  q_x;
		logic [QB-1:0]  q_y;
		logic           ovf_x;
		logic           ovf_y;
		logic [D_W-1:0] den;
		div_side_t      side;
	} div_stg_t;

	div_stg_t        stg_in;
	div_stg_t        stage_s [QB];
	logic [QB-1:0]   vld_s;

	always_comb begin
		stg_in.rem_x = num_x;
		stg_in.rem_y = num_y;
		stg_in.q_x   = '0;
		stg_in.q_y   = '0;
		// quotient would need more than QB bits
		stg_in.ovf_x = CMP_W'(num_x) >= (CMP_W'(den) << QB);
		stg_in.ovf_y = CMP_W'(num_y) >= (CMP_W'(den) << QB);
		stg_in.den   = den;
		stg_in.side  = side_in;
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int J = QB - 1 - k;
		div_stg_t         prev;
		div_stg_t         nxt;
		logic [CMP_W-1:0] sh;

		if (k == 0) begin : g_first
			assign prev = stg_in;
		end else begin : g_rest
			assign prev = stage_s[k-1];
		end

		always_comb begin
			nxt = prev;
			sh  = CMP_W'(prev.den) << J;
			if (CMP_W'(prev.rem_x) >= sh) begin
				nxt.rem_x  = N_W'(CMP_W'(prev.rem_x) - sh);
				nxt.q_x[J] = 1'b1;
			end
			if (CMP_W'(prev.rem_y) >= sh) begin
				nxt.rem_y  = N_W'(CMP_W'(prev.rem_y) - sh);
				nxt.q_y[J] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) stage_s[k] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QB-2:0], in_valid};
		end
	end

	assign out_valid = vld_s[QB-1];
	assign q_x       = stage_s[QB-1].q_x;
	assign q_y       = stage_s[QB-1].q_y;
	assign ovf_x     = stage_s[QB-1].ovf_x;
	assign ovf_y     = stage_s[QB-1].ovf_y;
	assign side_out  = stage_s[QB-1].side;

endmodule

FILE: hdl/reprojection_error_distorted_pinhole_top.sv
// Reprojection error of landmark observations through a distorted pinhole camera.
//
// Input channel obs (obs_valid/obs_ready) carries two kinds of item. A load item
// (action 0) writes one of the twelve pose words at once and gives no result; a
// project item (action 1) gives exactly one result item on res (res_valid/res_ready).
// Items may be mixed freely: a projection sees every load accepted before it.
// Throughput is one item per cycle while obs_ready is high. A projection's result
// passes through two transform stages (the first loads at the edge that accepts it),
// the 32-stage quotient pipeline for the depth division, twelve distortion and pixel
// stages, at most one multiply deep each, and the output register.
// The cfg port writes the eight camera registers (index 8 and up is ignored);
// write only while no projection is in flight.
// When res_ready is low the finished result holds in the output register and one
// more item lands in a skid register; only then does obs_ready drop and the whole
// pipeline freeze, so nothing is lost or repeated.
// Reset clears the pose to zero, sets focal lengths to 4096 and the other registers
// to zero, and empties the pipeline; no clearing pass is needed.
`include "reprojection_error_distorted_pinhole_top_defines.svh"

module reprojection_error_distorted_pinhole_top import rpe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 obs_valid,
	output logic                 obs_ready,
	input  obs_t                 obs,
	output logic                 res_valid,
	input  logic                 res_ready,
	output res_t                 res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	typedef struct packed {
		logic               bad;
		logic signed [31:0] meas_x;
		logic signed [31:0] meas_y;
	} carry_t;

	logic signed [31:0] pose_q [POSE_WORDS];
	logic signed [31:0] cfg_q  [NUM_REGS];

	logic en, accept;
	logic signed [31:0] pt [3];

	// valid chain
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;
	logic v_s10, v_s11, v_s12, v_s13, v_s14;

	// transform
	logic signed [33:0] pr_s1 [9];
	logic signed [31:0] tr_s1 [3];
	carry_t             ca_s1;
	logic signed [C_W-1:0] c_s2 [3];
	carry_t             ca_s2;

	// divider hookup
	logic [C_W-1:0] mag_x, mag_y;
	div_side_t      side_in, side_out;
	logic           dv;
	logic [QB-1:0]  dq_x, dq_y;
	logic           dovf_x, dovf_y;

	// post-division stages
	logic signed [33:0] qs_x, qs_y;
	logic [32:0]        sx, sy;
	logic signed [31:0] xn_s3, yn_s3;
	logic               sf_s3;
	carry_t             ca_s3;

	logic [32:0]        spxx, spyy, spxy;
	logic signed [31:0] pxx_s4, pyy_s4, pxy_s4, xn_s4, yn_s4;
	logic               sf_s4;
	carry_t             ca_s4;

	logic [32:0]        sr2, stx, sty;
	logic signed [31:0] r2_s5, tx_s5, ty_s5, pxy_s5, xn_s5, yn_s5;
	logic               sf_s5;
	carry_t             ca_s5;

	logic [32:0]        sr4;
	logic signed [31:0] r4_s6, xn_s6, yn_s6;
	logic signed [35:0] kr2_s6;
	logic signed [37:0] tpx_s6, tpy_s6;
	logic               sf_s6;
	carry_t             ca_s6;

	logic signed [35:0] kr2_s7, k2r4_s7;
	logic signed [37:0] tpx_s7, tpy_s7;
	logic signed [31:0] xn_s7, yn_s7;
	logic               sf_s7;
	carry_t             ca_s7;

	logic [32:0]        srad;
	logic signed [31:0] rad_s8, xn_s8, yn_s8;
	logic signed [37:0] tpx_s8, tpy_s8;
	logic               sf_s8;
	carry_t             ca_s8;

	logic signed [47:0] mx_s9, my_s9;
	logic signed [37:0] tpx_s9, tpy_s9;
	logic               sf_s9;
	carry_t             ca_s9;

	logic [32:0]        sxd, syd;
	logic signed [31:0] xd_s10, yd_s10;
	logic               sf_s10;
	carry_t             ca_s10;

	logic signed [47:0] fxd_s11, fyd_s11;
	logic               sf_s11;
	carry_t             ca_s11;

	logic signed [49:0] dx_s12, dy_s12;
	logic               sf_s12;
	logic               bad_s12;

	logic [49:0]        ax, ay;
	logic [63:0]        a_s13, b_s13;
	logic               sf_s13, bad_s13;

	logic [64:0]        sum_s14;
	logic               sf_s14, bad_s14;

	// output register and skid
	res_t res_new, res_q, skid_q;
	logic res_v_q, skid_v_q, push, take;

	assign en        = !skid_v_q;
	assign obs_ready = en;
	assign accept    = obs_valid && en;

	assign pt[0] = obs.point_x;
	assign pt[1] = obs.point_y;
	assign pt[2] = obs.point_z;

	// state: pose words and camera registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_WORDS; i++) pose_q[i] <= '0;
		end else if (accept && obs.action == ACT_LOAD && obs.pose_slot < SLOT_W'(POSE_WORDS)) begin
			pose_q[obs.pose_slot] <= obs.pose_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= (i == int'(REG_FX) || i == int'(REG_FY)) ? 32'sd4096 : 32'sd0;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7} <= '0;
			{v_s8, v_s9, v_s10, v_s11, v_s12, v_s13, v_s14} <= '0;
		end else if (en) begin
			v_s1  <= accept && obs.action == ACT_PROJECT;
			v_s2  <= v_s1;
			v_s3  <= dv;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// s1: rotation products, s2: camera coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 9; j++) begin
				pr_s1[j] <= 34'((64'(pose_q[j]) * 64'(pt[j % 3])) >>> 30);
			end
			for (int r = 0; r < 3; r++) tr_s1[r] <= pose_q[9 + r];
			ca_s1.bad    <= 1'b0;
			ca_s1.meas_x <= obs.measured_x;
			ca_s1.meas_y <= obs.measured_y;

			for (int r = 0; r < 3; r++) begin
				c_s2[r] <= C_W'(pr_s1[3*r]) + C_W'(pr_s1[3*r+1]) + C_W'(pr_s1[3*r+2]) +
				           C_W'(tr_s1[r]);
			end
			ca_s2 <= ca_s1;
		end
	end

	always_comb begin
		mag_x = c_s2[0][C_W-1] ? C_W'(-c_s2[0]) : C_W'(c_s2[0]);
		mag_y = c_s2[1][C_W-1] ? C_W'(-c_s2[1]) : C_W'(c_s2[1]);
		side_in.bad    = c_s2[2] <= C_W'(1);
		side_in.neg_x  = c_s2[0][C_W-1];
		side_in.neg_y  = c_s2[1][C_W-1];
		side_in.meas_x = ca_s2.meas_x;
		side_in.meas_y = ca_s2.meas_y;
	end

	rpe_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.num_x     ({mag_x, 16'b0}),
		.num_y     ({mag_y, 16'b0}),
		.den       (c_s2[2][D_W-1:0]),
		.side_in   (side_in),
		.out_valid (dv),
		.q_x       (dq_x),
		.q_y       (dq_y),
		.ovf_x     (dovf_x),
		.ovf_y     (dovf_y),
		.side_out  (side_out)
	);

	// quotient sign is applied after the magnitude division: truncation toward zero
	always_comb begin
		qs_x = signed'({2'b00, dq_x});
		qs_y = signed'({2'b00, dq_y});
		if (side_out.neg_x) qs_x = -qs_x;
		if (side_out.neg_y) qs_y = -qs_y;
		sx = sat_w(64'(qs_x));
		sy = sat_w(64'(qs_y));
	end

	always_comb begin
		spxx = sat_w((64'(xn_s3) * 64'(xn_s3)) >>> 16);
		spyy = sat_w((64'(yn_s3) * 64'(yn_s3)) >>> 16);
		spxy = sat_w((64'(xn_s3) * 64'(yn_s3)) >>> 16);
		sr2  = sat_w(64'(pxx_s4) + 64'(pyy_s4));
		stx  = sat_w(64'(signed'(sr2[31:0])) + 2 * 64'(pxx_s4));
		sty  = sat_w(64'(signed'(sr2[31:0])) + 2 * 64'(pyy_s4));
		sr4  = sat_w((64'(r2_s5) * 64'(r2_s5)) >>> 16);
		srad = sat_w(ONE_Q16 + 64'(kr2_s7) + 64'(k2r4_s7));
		sxd  = sat_w(64'(mx_s9) + 64'(tpx_s9));
		syd  = sat_w(64'(my_s9) + 64'(tpy_s9));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// s3: normalized coordinates
			xn_s3 <= sx[31:0];
			yn_s3 <= sy[31:0];
			sf_s3 <= dovf_x || dovf_y || sx[32] || sy[32];
			ca_s3.bad    <= side_out.bad;
			ca_s3.meas_x <= side_out.meas_x;
			ca_s3.meas_y <= side_out.meas_y;

			// s4: squares and cross product
			pxx_s4 <= spxx[31:0];
			pyy_s4 <= spyy[31:0];
			pxy_s4 <= spxy[31:0];
			xn_s4  <= xn_s3;
			yn_s4  <= yn_s3;
			sf_s4  <= sf_s3 || spxx[32] || spyy[32] || spxy[32];
			ca_s4  <= ca_s3;

			// s5: r^2 and tangential sums
			r2_s5  <= sr2[31:0];
			tx_s5  <= stx[31:0];
			ty_s5  <= sty[31:0];
			pxy_s5 <= pxy_s4;
			xn_s5  <= xn_s4;
			yn_s5  <= yn_s4;
			sf_s5  <= sf_s4 || sr2[32] || stx[32] || sty[32];
			ca_s5  <= ca_s4;

			// s6: r^4, k1 term, tangential offsets
			r4_s6  <= sr4[31:0];
			kr2_s6 <= 36'((64'(cfg_q[REG_K1]) * 64'(r2_s5)) >>> 28);
			tpx_s6 <= 38'((64'(cfg_q[REG_P1]) * 64'(pxy_s5)) >>> 27) +
			          38'((64'(cfg_q[REG_P2]) * 64'(tx_s5)) >>> 28);
			tpy_s6 <= 38'((64'(cfg_q[REG_P1]) * 64'(ty_s5)) >>> 28) +
			          38'((64'(cfg_q[REG_P2]) * 64'(pxy_s5)) >>> 27);
			xn_s6  <= xn_s5;
			yn_s6  <= yn_s5;
			sf_s6  <= sf_s5 || sr4[32];
			ca_s6  <= ca_s5;

			// s7: k2 term
			k2r4_s7 <= 36'((64'(cfg_q[REG_K2]) * 64'(r4_s6)) >>> 28);
			kr2_s7  <= kr2_s6;
			tpx_s7  <= tpx_s6;
			tpy_s7  <= tpy_s6;
			xn_s7   <= xn_s6;
			yn_s7   <= yn_s6;
			sf_s7   <= sf_s6;
			ca_s7   <= ca_s6;

			// s8: radial factor
			rad_s8 <= srad[31:0];
			tpx_s8 <= tpx_s7;
			tpy_s8 <= tpy_s7;
			xn_s8  <= xn_s7;
			yn_s8  <= yn_s7;
			sf_s8  <= sf_s7 || srad[32];
			ca_s8  <= ca_s7;

			// s9: radial scaling
			mx_s9  <= 48'((64'(xn_s8) * 64'(rad_s8)) >>> 16);
			my_s9  <= 48'((64'(yn_s8) * 64'(rad_s8)) >>> 16);
			tpx_s9 <= tpx_s8;
			tpy_s9 <= tpy_s8;
			sf_s9  <= sf_s8;
			ca_s9  <= ca_s8;

			// s10: distorted coordinates
			xd_s10 <= sxd[31:0];
			yd_s10 <= syd[31:0];
			sf_s10 <= sf_s9 || sxd[32] || syd[32];
			ca_s10 <= ca_s9;

			// s11: focal scaling
			fxd_s11 <= 48'((64'(cfg_q[REG_FX]) * 64'(xd_s10)) >>> 16);
			fyd_s11 <= 48'((64'(cfg_q[REG_FY]) * 64'(yd_s10)) >>> 16);
			sf_s11  <= sf_s10;
			ca_s11  <= ca_s10;

			// s12: pixel differences, full width
			dx_s12  <= 50'(fxd_s11) + 50'(cfg_q[REG_CX]) - 50'(ca_s11.meas_x);
			dy_s12  <= 50'(fyd_s11) + 50'(cfg_q[REG_CY]) - 50'(ca_s11.meas_y);
			sf_s12  <= sf_s11;
			bad_s12 <= ca_s11.bad;

			// s13: squares of magnitudes
			a_s13   <= 64'(ax[31:0]) * 64'(ax[31:0]);
			b_s13   <= 64'(ay[31:0]) * 64'(ay[31:0]);
			sf_s13  <= sf_s12 || (ax[49:32] != '0) || (ay[49:32] != '0);
			bad_s13 <= bad_s12;

			// s14: sum
			sum_s14 <= 65'(a_s13) + 65'(b_s13);
			sf_s14  <= sf_s13;
			bad_s14 <= bad_s13;
		end
	end

	always_comb begin
		ax = dx_s12[49] ? 50'(-dx_s12) : 50'(dx_s12);
		ay = dy_s12[49] ? 50'(-dy_s12) : 50'(dy_s12);
	end

	always_comb begin
		if (bad_s14) begin
			res_new.squared_error = '0;
			res_new.status        = STATUS_DEPTH;
		end else if (sf_s14 || sum_s14[64]) begin
			res_new.squared_error = '1;
			res_new.status        = STATUS_SAT;
		end else begin
			res_new.squared_error = sum_s14[63:0];
			res_new.status        = STATUS_OK;
		end
	end

	assign push = en && v_s14;
	assign take = res_v_q && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (push) begin
			if (!res_v_q || take) begin
				res_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (take) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!res_v_q || take) begin
				res_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (take && skid_v_q) begin
			res_q <= skid_q;
		end
	end

	assign res_valid = res_v_q;
	assign res       = res_q;

	`RPE_ASSERT(a_skid_behind_out, !skid_v_q || res_v_q)
	`RPE_ASSERT_NEXT(a_load_no_item, accept && obs.action == ACT_LOAD, !v_s1)
	`RPE_ASSERT_IMPL(a_depth_zero, res_v_q && res_q.status == STATUS_DEPTH,
		res_q.squared_error == '0)
	`RPE_ASSERT_IMPL(a_sat_ones, res_v_q && res_q.status == STATUS_SAT,
		res_q.squared_error == '1)

endmodule
